// ===== rtl/mecanum_wheel_speed_mixer_top_defines.svh =====
// Assertion macros for the wheel speed mixer checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef MECANUM_WHEEL_SPEED_MIXER_TOP_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define MWSM_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define MWSM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Checked in the cycle after reset is seen.
`define MWSM_ASSERT_AFTER_RESET(label, post, msg) \
  label: assert property (@(posedge clk) rst |=> (post)) else $error(msg);

`endif

// ===== rtl/mwsm_pkg.sv =====
// Shared types and constants for the mecanum wheel speed mixer.
// No dependencies.
package mwsm_pkg;

  localparam int LIM_BITS = 15;
  localparam int QUO_BITS = 15;
  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH = FRONT_STAGES + QUO_BITS + 1;
  localparam logic [LIM_BITS-1:0] LIM_RESET = '1;

  typedef enum logic [1:0] {
    REG_LIMIT_X,
    REG_LIMIT_Y,
    REG_LIMIT_SPIN,
    REG_WHEEL_LIMIT
  } mwsm_reg_t;

  typedef struct packed {
    logic [LIM_BITS-1:0] limit_x;
    logic [LIM_BITS-1:0] limit_y;
    logic [LIM_BITS-1:0] limit_spin;
    logic [LIM_BITS-1:0] wheel_limit;
  } mwsm_cfg_t;

  // Per-transaction side info carried down the divider row.
  typedef struct packed {
    logic       scale;
    logic [3:0] neg;
  } mwsm_ctl_t;

endpackage

// ===== rtl/mwsm_if.sv =====
// Valid/ready channel interfaces for body commands and wheel speeds.
// No dependencies.
interface mwsm_cmd_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vel_x;
  logic signed [W-1:0] vel_y;
  logic signed [W-1:0] vel_spin;

  modport source (output valid, vel_x, vel_y, vel_spin, input ready);
  modport sink (input valid, vel_x, vel_y, vel_spin, output ready);
endinterface

interface mwsm_wheel_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] wheel_a;
  logic signed [W-1:0] wheel_b;
  logic signed [W-1:0] wheel_c;
  logic signed [W-1:0] wheel_d;

  modport source (output valid, wheel_a, wheel_b, wheel_c, wheel_d, input ready);
  modport sink (input valid, wheel_a, wheel_b, wheel_c, wheel_d, output ready);
endinterface

// ===== rtl/mecanum_wheel_speed_mixer_top.sv =====
// Throughput: one transaction per cycle while the wheel output is not stalled;
// 4 front stages, a row of 15 divide cells (one quotient bit each) and one
// output register, each with its own valid.
// Reset: synchronous, clears every stage valid and sets all limits to 32767.
// Depends on mwsm_pkg, mwsm_if, mwsm_front, mwsm_div_cell and mwsm_back.
module mecanum_wheel_speed_mixer_top #(
  parameter int SPEED_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mwsm_cmd_if.sink                             cmd,
  mwsm_wheel_if.source                         wheel,
  input  logic                                 cfg_we,
  input  mwsm_pkg::mwsm_reg_t                  cfg_index,
  input  logic [mwsm_pkg::LIM_BITS-1:0]        cfg_data
);
  import mwsm_pkg::*;

  localparam int CW = (SPEED_BITS > 16) ? SPEED_BITS : 16;
  localparam int MW = CW + 1;
  localparam int PW = MW + LIM_BITS;

  mwsm_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_x     <= LIM_RESET;
      cfg.limit_y     <= LIM_RESET;
      cfg.limit_spin  <= LIM_RESET;
      cfg.wheel_limit <= LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT_X:     cfg.limit_x     <= cfg_data;
        REG_LIMIT_Y:     cfg.limit_y     <= cfg_data;
        REG_LIMIT_SPIN:  cfg.limit_spin  <= cfg_data;
        REG_WHEEL_LIMIT: cfg.wheel_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain taps: index 0 is the front output, index QUO_BITS the last cell.
  logic [QUO_BITS:0]          vld_c;
  logic [QUO_BITS:0]          rdy_c;
  mwsm_ctl_t                  ctl_c  [QUO_BITS+1];
  logic [3:0][PW-1:0]         rem_c  [QUO_BITS+1];
  logic [3:0][QUO_BITS-1:0]   quo_c  [QUO_BITS+1];
  logic [3:0][MW-1:0]         mag_c  [QUO_BITS+1];
  logic [MW-1:0]              peak_c [QUO_BITS+1];

  mwsm_front #(.S(SPEED_BITS), .CW(CW), .MW(MW), .PW(PW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .down_ready (rdy_c[0]),
    .valid      (vld_c[0]),
    .ctl        (ctl_c[0]),
    .rem        (rem_c[0]),
    .mag        (mag_c[0]),
    .peak       (peak_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
    mwsm_div_cell #(.MW(MW), .PW(PW), .K(QUO_BITS - 1 - g)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .valid_i    (vld_c[g]),
      .ctl_i      (ctl_c[g]),
      .rem_i      (rem_c[g]),
      .quo_i      (quo_c[g]),
      .mag_i      (mag_c[g]),
      .peak_i     (peak_c[g]),
      .ready      (rdy_c[g]),
      .down_ready (rdy_c[g+1]),
      .valid_o    (vld_c[g+1]),
      .ctl_o      (ctl_c[g+1]),
      .rem_o      (rem_c[g+1]),
      .quo_o      (quo_c[g+1]),
      .mag_o      (mag_c[g+1]),
      .peak_o     (peak_c[g+1])
    );
  end

  mwsm_back #(.S(SPEED_BITS), .MW(MW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .valid_i (vld_c[QUO_BITS]),
    .ctl_i   (ctl_c[QUO_BITS]),
    .quo_i   (quo_c[QUO_BITS]),
    .mag_i   (mag_c[QUO_BITS]),
    .ready   (rdy_c[QUO_BITS]),
    .wheel   (wheel)
  );

endmodule

// ===== rtl/mwsm_front.sv =====
// Front pipeline: clamp, wheel mix, peak magnitude and numerator product.
// Depends on mwsm_pkg and mwsm_cmd_if.
module mwsm_front #(
  parameter int S  = 16,
  parameter int CW = 16,
  parameter int MW = 17,
  parameter int PW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  mwsm_cmd_if.sink                         cmd,
  input  mwsm_pkg::mwsm_cfg_t              cfg,
  input  logic                             down_ready,
  output logic                             valid,
  output mwsm_pkg::mwsm_ctl_t              ctl,
  output logic [3:0][PW-1:0]               rem,
  output logic [3:0][MW-1:0]               mag,
  output logic [MW-1:0]                    peak
);
  import mwsm_pkg::*;

  localparam int TW = CW + 2;

  function automatic logic signed [CW-1:0] clamp_sym(input logic signed [S-1:0] v,
                                                     input logic [LIM_BITS-1:0] lim);
    logic signed [CW-1:0] ve;
    logic signed [CW-1:0] le;
    ve = CW'(v);
    le = $signed({{(CW-LIM_BITS){1'b0}}, lim});
    if (ve > le) return le;
    else if (ve < -le) return -le;
    else return ve;
  endfunction

  // stage 1: clamped command
  logic                 v1;
  logic signed [CW-1:0] x1, y1, w1;
  // stage 2: raw wheel speeds
  logic                 v2;
  logic [3:0][TW-1:0]   t2;
  // stage 3: magnitudes and peak
  logic                 v3;
  logic [3:0][MW-1:0]   m3;
  logic [MW-1:0]        peak3;
  mwsm_ctl_t            ctl3;

  logic rdy1, rdy2, rdy3, rdy4;
  assign rdy4 = !valid || down_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign cmd.ready = rdy1;

  logic signed [TW-1:0] xe, ye, we;
  assign xe = TW'(x1);
  assign ye = TW'(y1);
  assign we = TW'(w1);

  logic [3:0][MW-1:0] m_next;
  logic [3:0]         neg_next;
  logic [MW-1:0]      pk_lo, pk_hi, peak_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_next[i] = t2[i][TW-1];
      m_next[i]   = neg_next[i] ? MW'(-$signed(t2[i])) : MW'(t2[i]);
    end
    pk_lo     = (m_next[0] > m_next[1]) ? m_next[0] : m_next[1];
    pk_hi     = (m_next[2] > m_next[3]) ? m_next[2] : m_next[3];
    peak_next = (pk_lo > pk_hi) ? pk_lo : pk_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= cmd.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) valid <= v3;
    end
    if (rdy1 && cmd.valid) begin
      x1 <= clamp_sym(cmd.vel_x, cfg.limit_x);
      y1 <= clamp_sym(cmd.vel_y, cfg.limit_y);
      w1 <= clamp_sym(cmd.vel_spin, cfg.limit_spin);
    end
    if (rdy2 && v1) begin
      t2[0] <= xe - ye + we;
      t2[1] <= xe + ye + we;
      t2[2] <= -xe + ye + we;
      t2[3] <= -xe - ye + we;
    end
    if (rdy3 && v2) begin
      m3         <= m_next;
      peak3      <= peak_next;
      ctl3.neg   <= neg_next;
      ctl3.scale <= peak_next > MW'(cfg.wheel_limit);
    end
    if (rdy4 && v3) begin
      for (int i = 0; i < 4; i++) begin
        rem[i] <= PW'(m3[i]) * PW'(cfg.wheel_limit);
      end
      mag  <= m3;
      peak <= peak3;
      ctl  <= ctl3;
    end
  end

endmodule

// ===== rtl/mwsm_div_cell.sv =====
// One restoring division step for all four wheels: settles quotient bit K.
// Depends on mwsm_pkg.
module mwsm_div_cell #(
  parameter int MW = 17,
  parameter int PW = 32,
  parameter int K  = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid_i,
  input  mwsm_pkg::mwsm_ctl_t                  ctl_i,
  input  logic [3:0][PW-1:0]                   rem_i,
  input  logic [3:0][mwsm_pkg::QUO_BITS-1:0]   quo_i,
  input  logic [3:0][MW-1:0]                   mag_i,
  input  logic [MW-1:0]                        peak_i,
  output logic                                 ready,
  input  logic                                 down_ready,
  output logic                                 valid_o,
  output mwsm_pkg::mwsm_ctl_t                  ctl_o,
  output logic [3:0][PW-1:0]                   rem_o,
  output logic [3:0][mwsm_pkg::QUO_BITS-1:0]   quo_o,
  output logic [3:0][MW-1:0]                   mag_o,
  output logic [MW-1:0]                        peak_o
);
  import mwsm_pkg::*;

  logic [PW-1:0]                 dvs;
  logic [3:0][PW-1:0]            rem_next;
  logic [3:0][QUO_BITS-1:0]      quo_next;

  assign ready = !valid_o || down_ready;
  assign dvs   = PW'(peak_i) << K;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_next[i] = rem_i[i];
      quo_next[i] = quo_i[i];
      if (rem_i[i] >= dvs) begin
        rem_next[i]    = rem_i[i] - dvs;
        quo_next[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready) begin
      valid_o <= valid_i;
    end
    if (ready && valid_i) begin
      ctl_o  <= ctl_i;
      rem_o  <= rem_next;
      quo_o  <= quo_next;
      mag_o  <= mag_i;
      peak_o <= peak_i;
    end
  end

endmodule

// ===== rtl/mwsm_back.sv =====
// Output stage: pick scaled or raw magnitude, restore sign, saturate, register.
// Depends on mwsm_pkg and mwsm_wheel_if.
module mwsm_back #(
  parameter int S  = 16,
  parameter int MW = 17
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid_i,
  input  mwsm_pkg::mwsm_ctl_t                  ctl_i,
  input  logic [3:0][mwsm_pkg::QUO_BITS-1:0]   quo_i,
  input  logic [3:0][MW-1:0]                   mag_i,
  output logic                                 ready,
  mwsm_wheel_if.source                         wheel
);
  import mwsm_pkg::*;

  localparam int TW = MW + 1;
  localparam logic signed [TW-1:0] SMAX = TW'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SMIN = -SMAX - TW'(1);

  logic [3:0][S-1:0]     res;
  logic [MW-1:0]         m;
  logic signed [TW-1:0]  v;

  assign ready = !wheel.valid || wheel.ready;

  always_comb begin
    m = '0;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      m = ctl_i.scale ? MW'(quo_i[i]) : mag_i[i];
      v = ctl_i.neg[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (v > SMAX) res[i] = S'(SMAX);
      else if (v < SMIN) res[i] = S'(SMIN);
      else res[i] = S'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel.valid <= 1'b0;
    end else if (ready) begin
      wheel.valid <= valid_i;
    end
    if (ready && valid_i) begin
      wheel.wheel_a <= $signed(res[0]);
      wheel.wheel_b <= $signed(res[1]);
      wheel.wheel_c <= $signed(res[2]);
      wheel.wheel_d <= $signed(res[3]);
    end
  end

endmodule

// ===== rtl/mwsm_checker.sv =====
// Port-level checks for the wheel speed mixer, bound to the top level.
// Depends on mwsm_pkg and mecanum_wheel_speed_mixer_top_defines.svh.
`include "mecanum_wheel_speed_mixer_top_defines.svh"

module mwsm_checker #(
  parameter int SPEED_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [SPEED_BITS-1:0] wheel_a,
  input logic signed [SPEED_BITS-1:0] wheel_d
);
  import mwsm_pkg::*;

  localparam int CNT_BITS = $clog2(PIPE_DEPTH + 1) + 1;

  logic                in_acc;
  logic                out_acc;
  logic [CNT_BITS-1:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_BITS'(in_acc) - CNT_BITS'(out_acc);
    end
  end

  `MWSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output valid dropped while stalled")
  `MWSM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(wheel_a) && $stable(wheel_d), "output payload changed while stalled")
  `MWSM_ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "output valid right after reset")
  `MWSM_ASSERT_NOW(a_no_invent, out_valid, inflight != '0, "result without a pending command")
  `MWSM_ASSERT_NOW(a_depth, 1'b1, inflight <= CNT_BITS'(PIPE_DEPTH), "more commands in flight than stages")

endmodule

bind mecanum_wheel_speed_mixer_top mwsm_checker #(.SPEED_BITS(SPEED_BITS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .out_valid (wheel.valid),
  .out_ready (wheel.ready),
  .wheel_a   (wheel.wheel_a),
  .wheel_d   (wheel.wheel_d)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for mecanum_wheel_speed_mixer_top: a directed table, then random
// commands under random limit settings, with random stalls on both channels.
// Depends on mwsm_pkg, the channel interfaces in mwsm_if and the mixer RTL.
module testbench;
  import mwsm_pkg::*;

  localparam int SPD = 16;
  localparam int SPD_MAX = 2 ** (SPD - 1) - 1;
  localparam int SPD_MIN = -SPD_MAX - 1;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP = 14;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_CMDS = 105;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic signed [SPD-1:0] wheel_a;
    logic signed [SPD-1:0] wheel_b;
    logic signed [SPD-1:0] wheel_c;
    logic signed [SPD-1:0] wheel_d;
  } wheel_set_t;

  typedef enum logic {ROW_LIMITS, ROW_CMD} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    mwsm_cfg_t             lims;
    logic signed [SPD-1:0] vel_x;
    logic signed [SPD-1:0] vel_y;
    logic signed [SPD-1:0] vel_spin;
    bit                    typed;
    wheel_set_t            want;
  } drive_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  mwsm_reg_t           cfg_index;
  logic [LIM_BITS-1:0] cfg_data;

  mwsm_cmd_if #(.W(SPD)) cmd_ch ();
  mwsm_wheel_if #(.W(SPD)) wheel_ch ();

  mecanum_wheel_speed_mixer_top #(.SPEED_BITS(SPD)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .wheel     (wheel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mwsm_cfg_t  lim_shadow = '{LIM_RESET, LIM_RESET, LIM_RESET, LIM_RESET};
  wheel_set_t pending_wheels[$];
  drive_row_t plan[$];
  int         mismatch_count = 0;
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  bit         rx_hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int clamp_cmd(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Clamp, mix and desaturate one body command under the current limits.
  function automatic wheel_set_t mix_wheels(logic signed [SPD-1:0] vx,
                                            logic signed [SPD-1:0] vy,
                                            logic signed [SPD-1:0] vs);
    int         x, y, w, peak, mag, wl;
    int         t[4];
    longint     s;
    wheel_set_t r;
    x = clamp_cmd(int'(vx), int'(lim_shadow.limit_x));
    y = clamp_cmd(int'(vy), int'(lim_shadow.limit_y));
    w = clamp_cmd(int'(vs), int'(lim_shadow.limit_spin));
    wl = int'(lim_shadow.wheel_limit);
    t[0] = x - y + w;
    t[1] = x + y + w;
    t[2] = -x + y + w;
    t[3] = -x - y + w;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag = t[i] < 0 ? -t[i] : t[i];
      if (mag > peak) peak = mag;
    end
    for (int i = 0; i < 4; i++) begin
      s = t[i];
      if (peak > wl) begin
        // truncate the magnitude, then restore the sign
        mag = t[i] < 0 ? -t[i] : t[i];
        s = (longint'(mag) * longint'(wl)) / peak;
        if (t[i] < 0) s = -s;
      end
      if (s > SPD_MAX) s = SPD_MAX;
      else if (s < SPD_MIN) s = SPD_MIN;
      t[i] = int'(s);
    end
    r.wheel_a = SPD'(t[0]);
    r.wheel_b = SPD'(t[1]);
    r.wheel_c = SPD'(t[2]);
    r.wheel_d = SPD'(t[3]);
    return r;
  endfunction

  function automatic drive_row_t cmd_row(int vx, int vy, int vs, int typed = 0,
                                         int a = 0, int b = 0, int c = 0, int d = 0);
    drive_row_t r;
    r.kind = ROW_CMD;
    r.lims = '0;
    r.vel_x = SPD'(vx);
    r.vel_y = SPD'(vy);
    r.vel_spin = SPD'(vs);
    r.typed = (typed != 0);
    r.want = '{SPD'(a), SPD'(b), SPD'(c), SPD'(d)};
    return r;
  endfunction

  function automatic drive_row_t lims_row(int lx, int ly, int ls, int wl);
    drive_row_t r;
    r = cmd_row(0, 0, 0);
    r.kind = ROW_LIMITS;
    r.lims = '{LIM_BITS'(lx), LIM_BITS'(ly), LIM_BITS'(ls), LIM_BITS'(wl)};
    return r;
  endfunction

  function automatic int pick_speed();
    case ($urandom_range(0, 9))
      0: return SPD_MAX;
      1: return SPD_MIN;
      2: return int'($urandom_range(0, 600)) - 300;
      3: return 0;
      default: return int'($signed(SPD'($urandom())));
    endcase
  endfunction

  function automatic logic [LIM_BITS-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0, 1: return LIM_RESET;
      2: return '0;
      3: return LIM_BITS'(1);
      4, 5: return LIM_BITS'($urandom_range(2, 300));
      default: return LIM_BITS'($urandom());
    endcase
  endfunction

  function automatic void check_wheel(string name, logic signed [SPD-1:0] want,
                                      logic signed [SPD-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Write all four limit registers back to back; the block must be idle.
  task automatic apply_limits(mwsm_cfg_t lims);
    cfg_we <= 1'b1;
    cfg_index <= REG_LIMIT_X;
    cfg_data <= lims.limit_x;
    @(posedge clk);
    cfg_index <= REG_LIMIT_Y;
    cfg_data <= lims.limit_y;
    @(posedge clk);
    cfg_index <= REG_LIMIT_SPIN;
    cfg_data <= lims.limit_spin;
    @(posedge clk);
    cfg_index <= REG_WHEEL_LIMIT;
    cfg_data <= lims.wheel_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_shadow = lims;
  endtask

  // Drop valid and hold until every wheel set is back and the pipe is empty.
  task automatic settle_pipe();
    cmd_ch.valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic issue_command(drive_row_t row);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.vel_x <= row.vel_x;
    cmd_ch.vel_y <= row.vel_y;
    cmd_ch.vel_spin <= row.vel_spin;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_wheels.push_back(row.typed ? row.want
                                       : mix_wheels(row.vel_x, row.vel_y, row.vel_spin));
  endtask

  initial begin : stimulus
    mwsm_cfg_t lims;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_LIMIT_X;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.vel_x <= '0;
    cmd_ch.vel_y <= '0;
    cmd_ch.vel_spin <= '0;
    wheel_ch.ready <= 1'b0;

    // limits at reset value
    plan.push_back(cmd_row(0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(cmd_row(100, 0, 0, 1, 100, 100, -100, -100));
    plan.push_back(cmd_row(0, 100, 0, 1, -100, 100, 100, -100));
    plan.push_back(cmd_row(0, 0, -100, 1, -100, -100, -100, -100));
    plan.push_back(cmd_row(32767, 0, 0, 1, 32767, 32767, -32767, -32767));
    plan.push_back(cmd_row(-32768, 0, 0, 1, -32767, -32767, 32767, 32767));
    plan.push_back(cmd_row(32767, 32767, 32767, 1, 10922, 32767, 10922, -10922));
    plan.push_back(cmd_row(-32768, -32768, -32768, 1, -10922, -32767, -10922, 10922));
    plan.push_back(cmd_row(32767, -32768, 0, 1, 32767, 0, -32767, 0));
    plan.push_back(cmd_row(21845, -21846, 0));
    plan.push_back(cmd_row(-21846, 21845, 21845));
    plan.push_back(cmd_row(1, -1, 1));
    // zero command limits force every component to zero
    plan.push_back(lims_row(0, 0, 0, 0));
    plan.push_back(cmd_row(32767, -32768, -32768, 1, 0, 0, 0, 0));
    plan.push_back(cmd_row(-1, 1, 12345, 1, 0, 0, 0, 0));
    // zero wheel limit scales any nonzero set to zero
    plan.push_back(lims_row(32767, 32767, 32767, 0));
    plan.push_back(cmd_row(5, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(cmd_row(-32768, 32767, -32768, 1, 0, 0, 0, 0));
    plan.push_back(lims_row(32767, 32767, 32767, 1));
    plan.push_back(cmd_row(3, 0, 0, 1, 1, 1, -1, -1));
    plan.push_back(cmd_row(0, 0, 1, 1, 1, 1, 1, 1));
    plan.push_back(cmd_row(2, 1, 0));
    plan.push_back(lims_row(1000, 200, 50, 1200));
    plan.push_back(cmd_row(32767, -32768, 32767));
    plan.push_back(cmd_row(-500, 150, -40));
    plan.push_back(cmd_row(900, -200, 50));
    plan.push_back(lims_row(1, 1, 1, 32767));
    plan.push_back(cmd_row(-32768, 32767, -1, 1, -3, -1, 1, -1));
    plan.push_back(cmd_row(32767, -32768, 1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMITS) begin
        settle_pipe();
        apply_limits(plan[i].lims);
      end else begin
        issue_command(plan[i]);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_pipe();
      if (p == 0) begin
        lims = '{LIM_RESET, LIM_RESET, LIM_RESET, LIM_RESET};
      end else begin
        lims = '{pick_limit(), pick_limit(), pick_limit(), pick_limit()};
      end
      apply_limits(lims);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 4 == 2);
      if (p == 5) begin
        // stall the wheel side while commands keep coming, so the input backs up
        tx_steady = 1'b1;
        rx_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (p == 3 && n == PHASE_CMDS / 2) settle_pipe();
        issue_command(cmd_row(pick_speed(), pick_speed(), pick_speed()));
      end
    end

    settle_pipe();
    if (mismatch_count == 0) begin
      $display("** mecanum_wheel_speed_mixer_top: PASSED **");
    end else begin
      $display("** mecanum_wheel_speed_mixer_top: FAILED **");
    end
    $finish;
  end

  initial begin : wheel_drain
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        wheel_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        wheel_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      wheel_ch.ready <= 1'b1;
      do @(posedge clk); while (!wheel_ch.valid && !rx_hold_req);
    end
  end

  always @(posedge clk) begin : wheel_check
    wheel_set_t want;
    if (!rst && wheel_ch.valid && wheel_ch.ready) begin
      if (pending_wheels.size() == 0) begin
        $error("unexpected wheel transaction: %0d %0d %0d %0d", wheel_ch.wheel_a,
               wheel_ch.wheel_b, wheel_ch.wheel_c, wheel_ch.wheel_d);
        mismatch_count++;
      end else begin
        want = pending_wheels.pop_front();
        check_wheel("wheel_a", want.wheel_a, wheel_ch.wheel_a);
        check_wheel("wheel_b", want.wheel_b, wheel_ch.wheel_b);
        check_wheel("wheel_c", want.wheel_c, wheel_ch.wheel_c);
        check_wheel("wheel_d", want.wheel_d, wheel_ch.wheel_d);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** mecanum_wheel_speed_mixer_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mwsm_pkg.sv
rtl/mwsm_if.sv
rtl/mwsm_front.sv
rtl/mwsm_div_cell.sv
rtl/mwsm_back.sv
rtl/mecanum_wheel_speed_mixer_top.sv
rtl/mwsm_checker.sv
tb/testbench.sv
